/* hdl/mpq_sh_pkg.sv */
// shared types and constants for the mpq string hash block
`default_nettype none

package mpq_sh_pkg;

  localparam logic [31:0] SEED_ONE_INIT = 32'h7FED7FED;
  localparam logic [31:0] SEED_TWO_INIT = 32'hEEEEEEEE;
  localparam logic [31:0] SEED_TWO_INC  = 32'd3;

  // table generator: s = (s * 125 + 3) mod 0x2AAAAB
  localparam int          LCG_W     = 22;
  localparam logic [21:0] LCG_MOD   = 22'h2AAAAB;
  localparam logic [21:0] LCG_START = 22'h100001;
  localparam logic [6:0]  LCG_MUL   = 7'd125;
  localparam logic [21:0] LCG_INC   = 22'd3;
  localparam logic [2:0]  LCG_LAST_STEP = 3'd7;

  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_CASE    = 8'h20;

  typedef enum logic {
    ST_FILL,
    ST_RUN
  } sh_state_t;

endpackage

`default_nettype wire

/* hdl/mpq_string_hash_top.sv */
// mpq two-seed string hash: table memory, fill sequencer and seed pipeline
//
//  channel | dir | beat contents
//  --------+-----+------------------------------------------------------
//  in_     | in  | tdata[7:0] char_byte, tlast last_char
//  out_    | out | tdata[31:0] hash_value, one beat per string
//  cfg_    | in  | wr_data[2:0] hash_type, written when wr_en is high
//
// one byte per cycle sustained while no hash waits unread on out_; the last byte's table word is
// read into rd_data_r at the accepting edge, then the seed mix puts the hash in out_data_r.
// the seed mix loop sets the rate.
// after reset the crypt table is generated into the memory: NUM_HASH_TYPES*256
// words, two lcg values per word (high half first), in_tready low.
// after the fill, in_tready drops only while a last byte waits behind an unread hash.
`default_nettype none

module mpq_string_hash_top #(
  parameter int NUM_HASH_TYPES = 5
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,    // [7:0] char_byte
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,   // [31:0] hash_value
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_wr_data
);

  import mpq_sh_pkg::*;

  localparam int KW     = (NUM_HASH_TYPES > 1) ? $clog2(NUM_HASH_TYPES) : 1;
  localparam int ADDR_W = KW + 8;
  localparam int DEPTH  = NUM_HASH_TYPES * 256;

  // configuration
  logic [2:0] hash_type_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_type_r <= '0;
    end else if (cfg_wr_en) begin
      hash_type_r <= cfg_wr_data;
    end
  end

  // fill sequencer
  sh_state_t          state_r, state_nxt;
  logic [LCG_W-1:0]   lcg_s_r, lcg_s_nxt;
  logic [LCG_W-1:0]   acc_r, acc_nxt;
  logic [2:0]         stp_r, stp_nxt;
  logic               half_r, half_nxt;
  logic [15:0]        hi_r, hi_nxt;
  logic [7:0]         fill_b_r, fill_b_nxt;
  logic [KW-1:0]      fill_k_r, fill_k_nxt;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [31:0]        mem_wdata;

  logic [LCG_W:0] dbl, dbl_red, add_s, add_red, inc_s, inc_red;
  logic [2:0]     bit_idx;

  always_comb begin
    bit_idx = 3'd6 - stp_r;
    dbl     = (stp_r == '0) ? '0 : {acc_r, 1'b0};
    dbl_red = (dbl >= {1'b0, LCG_MOD}) ? dbl - {1'b0, LCG_MOD} : dbl;
    add_s   = dbl_red + {1'b0, lcg_s_r};
    add_red = (add_s >= {1'b0, LCG_MOD}) ? add_s - {1'b0, LCG_MOD} : add_s;
    inc_s   = {1'b0, acc_r} + {1'b0, LCG_INC};
    inc_red = (inc_s >= {1'b0, LCG_MOD}) ? inc_s - {1'b0, LCG_MOD} : inc_s;
  end

  always_comb begin
    state_nxt  = state_r;
    lcg_s_nxt  = lcg_s_r;
    acc_nxt    = acc_r;
    stp_nxt    = stp_r;
    half_nxt   = half_r;
    hi_nxt     = hi_r;
    fill_b_nxt = fill_b_r;
    fill_k_nxt = fill_k_r;
    mem_we     = 1'b0;
    mem_waddr  = {fill_k_r, fill_b_r};
    mem_wdata  = {hi_r, inc_red[15:0]};
    case (state_r)
      ST_FILL: begin
        stp_nxt = stp_r + 3'd1;
        if (stp_r != LCG_LAST_STEP) begin
          // horner step of s * 125 mod m, msb of the multiplier first
          acc_nxt = LCG_MUL[bit_idx] ? add_red[LCG_W-1:0] : dbl_red[LCG_W-1:0];
        end else begin
          lcg_s_nxt = inc_red[LCG_W-1:0];
          half_nxt  = !half_r;
          if (!half_r) begin
            hi_nxt = inc_red[15:0];
          end else begin
            mem_we = 1'b1;
            if (fill_k_r == KW'(NUM_HASH_TYPES - 1)) begin
              fill_k_nxt = '0;
              fill_b_nxt = fill_b_r + 8'd1;
              if (fill_b_r == 8'hFF) begin
                state_nxt = ST_RUN;
              end
            end else begin
              fill_k_nxt = fill_k_r + KW'(1);
            end
          end
        end
      end
      ST_RUN: begin
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_FILL;
      lcg_s_r  <= LCG_START;
      stp_r    <= '0;
      half_r   <= 1'b0;
      fill_b_r <= '0;
      fill_k_r <= '0;
    end else begin
      state_r  <= state_nxt;
      lcg_s_r  <= lcg_s_nxt;
      stp_r    <= stp_nxt;
      half_r   <= half_nxt;
      fill_b_r <= fill_b_nxt;
      fill_k_r <= fill_k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    hi_r  <= hi_nxt;
  end

  // input stage: upper-case and table address
  logic              in_acc;
  logic [7:0]        ch_up;
  logic [ADDR_W-1:0] mem_raddr;
  logic              type_ok;

  assign in_acc    = in_tvalid && in_tready;
  assign ch_up     = (in_tdata >= CHAR_LOWER_A && in_tdata <= CHAR_LOWER_Z) ?
                     in_tdata - CHAR_CASE : in_tdata;
  assign mem_raddr = {hash_type_r[KW-1:0], ch_up};
  assign type_ok   = (int'(hash_type_r) < NUM_HASH_TYPES);

  // crypt table memory
  logic [31:0] crypt_mem [DEPTH];
  logic [31:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      crypt_mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rd_data_r <= crypt_mem[mem_raddr];
    end
  end

  // mix stage
  logic        s1_valid_r;
  logic        s1_last_r;
  logic [7:0]  s1_ch_r;
  logic        s1_tok_r;
  logic        s1_go;
  logic [31:0] seed_one_r, seed_one_nxt;
  logic [31:0] seed_two_r, seed_two_nxt;
  logic [31:0] word;
  logic        out_valid_r;
  logic [31:0] out_data_r;

  assign s1_go     = s1_valid_r && (!s1_last_r || !out_valid_r || out_tready);
  assign in_tready = (state_r == ST_RUN) && (!s1_valid_r || s1_go);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_last_r <= in_tlast;
      s1_ch_r   <= ch_up;
      s1_tok_r  <= type_ok;
    end
  end

  always_comb begin
    word         = s1_tok_r ? rd_data_r : '0;
    seed_one_nxt = word ^ (seed_one_r + seed_two_r);
    seed_two_nxt = seed_one_nxt + seed_two_r + {seed_two_r[26:0], 5'b0} +
                   {24'b0, s1_ch_r} + SEED_TWO_INC;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_one_r <= SEED_ONE_INIT;
      seed_two_r <= SEED_TWO_INIT;
    end else if (s1_go) begin
      if (s1_last_r) begin
        seed_one_r <= SEED_ONE_INIT;
        seed_two_r <= SEED_TWO_INIT;
      end else begin
        seed_one_r <= seed_one_nxt;
        seed_two_r <= seed_two_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last_r) begin
      out_data_r <= seed_one_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // checks
  a_no_accept_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> state_r == ST_RUN)
    else $error("byte accepted while the table is still being filled");

  a_seed_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_last_r) |=>
      (seed_one_r == SEED_ONE_INIT && seed_two_r == SEED_TWO_INIT))
    else $error("seeds not restarted after the last byte");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r && s1_last_r))
    else $error("hash beat without a last byte in the mix stage");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && s1_valid_r && s1_last_r) |-> !s1_go)
    else $error("pending hash overwritten");

endmodule

`default_nettype wire

/* dv/testbench.sv */
// testbench for the mpq string hash block: predicts every string hash and checks each beat
`timescale 1ns / 1ps

module testbench;
  import mpq_sh_pkg::*;

  localparam int N_SLICES     = 5;
  localparam int FLUSH_WAIT   = 4;
  localparam int HOLD_LEN     = 300;
  localparam int RANDOM_BYTES = 650;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum logic [1:0] {
    RX_FREE,
    RX_CHOPPY,
    RX_SLOW
  } rx_style_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;      // [7:0] char_byte
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;          // [31:0] hash_value
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_wr_data = '0;

  logic [31:0] crypt_words [N_SLICES*256];
  logic [31:0] seed_a = SEED_ONE_INIT;
  logic [31:0] seed_b = SEED_TWO_INIT;
  logic [2:0]  cur_slice = '0;
  logic [31:0] hashes_due [$];

  int        errors = 0;
  int        cycle_count = 0;
  int        hold_requests = 0;
  int        holds_served = 0;
  int        hold_left = 0;
  int        burst_left = 0;
  bit        tx_gappy = 1'b0;
  rx_style_t rx_style = RX_FREE;
  int        rx_style_left = 0;

  mpq_string_hash_top #(
    .NUM_HASH_TYPES(N_SLICES)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("mpq_string_hash_top: mismatch");
      $finish;
    end
  end

  function automatic logic [31:0] lcg_step(input logic [31:0] s);
    return (s * 125 + 3) % 32'h2AAAAB;
  endfunction

  // byte-major order: all slices of one byte, then the next byte
  function automatic void build_crypt_words();
    logic [31:0] s;
    logic [31:0] hi;
    s = 32'h00100001;
    for (int b = 0; b < 256; b++) begin
      for (int k = 0; k < N_SLICES; k++) begin
        s = lcg_step(s);
        hi = s;
        s = lcg_step(s);
        crypt_words[k*256 + b] = {hi[15:0], s[15:0]};
      end
    end
  endfunction

  function automatic void hash_byte(input logic [7:0] raw, input logic fin);
    logic [7:0]  ch;
    logic [31:0] word;
    ch = raw;
    if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) ch = ch - CHAR_CASE;
    // slices past the table read as zero
    word = (cur_slice < N_SLICES) ? crypt_words[cur_slice*256 + ch] : 32'd0;
    seed_a = word ^ (seed_a + seed_b);
    seed_b = {24'd0, ch} + seed_a + seed_b + (seed_b << 5) + SEED_TWO_INC;
    if (fin) begin
      hashes_due.push_back(seed_a);
      seed_a = SEED_ONE_INIT;
      seed_b = SEED_TWO_INIT;
    end
  endfunction

  // check result first, then predict from the input beat of the same edge
  always @(posedge clk) begin : scoreboard
    logic [31:0] want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (hashes_due.size() == 0) begin
          errors++;
          $display("%0t: hash_value expected none actual %h", $time, out_tdata);
        end else begin
          want = hashes_due.pop_front();
          if (out_tdata !== want) begin
            errors++;
            $display("%0t: hash_value expected %h actual %h", $time, want, out_tdata);
          end
        end
      end
      if (in_tvalid && in_tready) hash_byte(in_tdata, in_tlast);
      if (cfg_wr_en) cur_slice = cfg_wr_data;
    end
  end

  always @(posedge clk) begin : receiver
    if (rx_style_left == 0) begin
      rx_style = rx_style_t'($urandom_range(0, 2));
      rx_style_left = $urandom_range(20, 200);
    end else begin
      rx_style_left--;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = HOLD_LEN;
      out_tready <= 1'b0;
    end else begin
      case (rx_style)
        RX_FREE:   out_tready <= 1'b1;
        RX_CHOPPY: out_tready <= ($urandom_range(0, 2) != 0);
        default:   out_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 3))
      0:       return 8'($urandom_range(0, 255));
      1:       return 8'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Z));
      2:       return 8'($urandom_range(CHAR_LOWER_A, CHAR_LOWER_Z)) - CHAR_CASE;
      default: return $urandom_range(0, 1) ? CHAR_LOWER_A - 8'd1 : CHAR_LOWER_Z + 8'd1;
    endcase
  endfunction

  function automatic logic [2:0] pick_slice();
    if ($urandom_range(0, 9) < 7) return 3'($urandom_range(0, N_SLICES - 1));
    return 3'($urandom_range(N_SLICES, 7));
  endfunction

  task automatic send_byte(input logic [7:0] ch, input logic fin);
    int gap;
    if (tx_gappy && burst_left == 0) begin
      gap = $urandom_range(0, 5);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    if (burst_left > 0) burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= fin;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // stop sending and wait until the pipeline has nothing left in flight
  task automatic settle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (hashes_due.size() != 0) @(posedge clk);
    repeat (FLUSH_WAIT) @(posedge clk);
  endtask

  task automatic set_slice(input logic [2:0] v);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic test_directed();
    tx_gappy = 1'b0;
    set_slice(3'd0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(CHAR_LOWER_A, 1'b1);
    send_byte(CHAR_LOWER_A - CHAR_CASE, 1'b1);
    send_byte(CHAR_LOWER_A - 8'd1, 1'b1);
    send_byte(CHAR_LOWER_Z, 1'b1);
    send_byte(CHAR_LOWER_Z + 8'd1, 1'b1);
    send_text("abc");
    set_slice(3'd4);
    send_byte(8'hFF, 1'b1);
    send_text("Zz");
    // slices past the table
    set_slice(3'd5);
    send_byte(8'h41, 1'b1);
    set_slice(3'd7);
    send_text("az");
    // slice change in the middle of a string
    set_slice(3'd0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    set_slice(3'd2);
    send_byte(8'h63, 1'b1);
    settle();
  endtask

  // long receiver hold with the sender pushing short strings behind it
  task automatic test_backpressure();
    int len;
    set_slice(3'($urandom_range(0, N_SLICES - 1)));
    tx_gappy = 1'b0;
    hold_requests++;
    repeat (40) begin
      len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++) send_byte(pick_char(), i == len - 1);
    end
    settle();
  endtask

  task automatic test_random();
    int sent;
    int len;
    int strings;
    sent = 0;
    strings = 0;
    while (sent < RANDOM_BYTES) begin
      if (strings % 16 == 0) begin
        set_slice(pick_slice());
        tx_gappy = ($urandom_range(0, 3) != 0);
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        if (len > 4 && i == len / 2 && $urandom_range(0, 7) == 0) set_slice(pick_slice());
        send_byte(pick_char(), i == len - 1);
      end
      sent += len;
      strings++;
    end
    settle();
  endtask

  initial begin
    build_crypt_words();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // table fill runs after reset with in_tready low
    do @(posedge clk); while (!in_tready);
    test_directed();
    test_backpressure();
    test_random();
    settle();
    if (errors == 0) begin
      $display("mpq_string_hash_top: match");
    end else begin
      $display("mpq_string_hash_top: mismatch");
    end
    $finish;
  end

endmodule
